// ===== rtl/core/mexn_pkg.sv =====
// ----------------------------------------------------------------------------
// mexn_pkg
// Types, codes and helpers shared by the mutual exclusion node.
// ----------------------------------------------------------------------------
package mexn_pkg;

   localparam int unsigned MAX_NODES_DEF   = 16;
   localparam int unsigned STAMP_LIMIT_DEF = 256;

   localparam int unsigned KIND_W  = 2;
   localparam int unsigned PEER_W  = 4;
   localparam int unsigned STAMP_W = 8;
   localparam int unsigned PEER_N  = 1 << PEER_W;
   localparam int unsigned NODE_W  = 5;
   localparam int unsigned CNT_W   = 7;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 5;
   localparam int unsigned QUEUE_DEPTH = 2;

   typedef enum logic [KIND_W-1:0] {
      KIND_LOCAL_REQ = 2'd0,
      KIND_PEER_REQ  = 2'd1,
      KIND_PERMIT    = 2'd2,
      KIND_RELEASE   = 2'd3
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OWN_ID     = 2'd0,
      CSR_NODE_COUNT = 2'd1,
      CSR_SPARE_2    = 2'd2,
      CSR_SPARE_3    = 2'd3
   } csr_index_type;

   localparam logic EV_PERMIT = 1'b0;
   localparam logic EV_GRANT  = 1'b1;

   typedef struct packed {
      logic [PEER_W-1:0] own_id;
      logic [NODE_W-1:0] node_count;
   } cfg_type;

   typedef struct packed {
      kind_type           kind;
      logic [PEER_W-1:0]  peer;
      logic [STAMP_W-1:0] stamp;
   } cmd_type;

   // node count clamped into 1..max_n
   function automatic logic [CNT_W-1:0] eff_nodes(input logic [NODE_W-1:0] nc,
                                                  input logic [CNT_W-1:0] max_n);
      logic [CNT_W-1:0] ext;
      ext = CNT_W'(nc);
      if (ext == '0) begin
         return CNT_W'(1);
      end
      if (ext > max_n) begin
         return max_n;
      end
      return ext;
   endfunction

endpackage

// ===== rtl/core/mexn_if.sv =====
// ----------------------------------------------------------------------------
// mexn channel interfaces
// Valid/ready channels for event items, result items and register writes.
// ----------------------------------------------------------------------------
interface mexn_req_if;
   import mexn_pkg::*;
   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  kind;
   logic [PEER_W-1:0]  peer;
   logic [STAMP_W-1:0] stamp;

   modport source (output valid, kind, peer, stamp, input ready);
   modport sink   (input valid, kind, peer, stamp, output ready);
endinterface

interface mexn_rsp_if;
   import mexn_pkg::*;
   logic              valid;
   logic              ready;
   logic              event_res;
   logic [PEER_W-1:0] dest;
   logic              last;

   modport source (output valid, event_res, dest, last, input ready);
   modport sink   (input valid, event_res, dest, last, output ready);
endinterface

interface mexn_csr_if;
   import mexn_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/mexn_front.sv =====
// ----------------------------------------------------------------------------
// mexn_front
// Accepts event items, drops those naming an invalid peer, saturates stamps.
// ----------------------------------------------------------------------------
module mexn_front
   import mexn_pkg::*;
#(
   parameter int unsigned MAX_NODES   = MAX_NODES_DEF,
   parameter int unsigned STAMP_LIMIT = STAMP_LIMIT_DEF
) (
   mexn_req_if.sink req,
   input  cfg_type  cfg,
   input  logic     q_full,
   output logic     push,
   output cmd_type  push_cmd
);

   localparam int unsigned SAT_VAL = (STAMP_LIMIT > (1 << STAMP_W)) ?
                                     ((1 << STAMP_W) - 1) : (STAMP_LIMIT - 1);
   localparam logic [STAMP_W-1:0] STAMP_MAX = STAMP_W'(SAT_VAL);
   localparam logic [CNT_W-1:0]   MAX_N     = CNT_W'(MAX_NODES);

   logic [CNT_W-1:0] n_eff;
   logic             valid_peer;
   logic             keep;
   kind_type         kind;

   assign kind       = kind_type'(req.kind);
   assign n_eff      = eff_nodes(cfg.node_count, MAX_N);
   assign valid_peer = (req.peer != cfg.own_id) && (CNT_W'(req.peer) < n_eff);

   always_comb begin
      unique case (kind) inside
         KIND_PEER_REQ, KIND_PERMIT: keep = valid_peer;
         default:                    keep = 1'b1;
      endcase
   end

   assign req.ready      = !q_full;
   assign push           = req.valid && !q_full && keep;
   assign push_cmd.kind  = kind;
   assign push_cmd.peer  = req.peer;
   assign push_cmd.stamp = (req.stamp > STAMP_MAX) ? STAMP_MAX : req.stamp;

endmodule

// ===== rtl/core/mexn_queue.sv =====
// ----------------------------------------------------------------------------
// mexn_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module mexn_queue
   import mexn_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    pop_valid,
   output cmd_type pop_cmd
);

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_QW = $clog2(QUEUE_DEPTH + 1);

   cmd_type            slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_QW-1:0]  count_ff, count_in;
   logic               do_push, do_pop;

   assign full      = (count_ff == CNT_QW'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_cmd   = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_QW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_QW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== rtl/core/mexn_back.sv =====
// ----------------------------------------------------------------------------
// mexn_back
// Protocol state, permission bookkeeping, release drain and result register.
// ----------------------------------------------------------------------------
module mexn_back
   import mexn_pkg::*;
#(
   parameter int unsigned MAX_NODES = MAX_NODES_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     q_valid,
   input  cmd_type  q_cmd,
   output logic     pop,
   mexn_rsp_if.source rsp
);

   localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_NODES);

   typedef enum logic [1:0] {
      ST_RUN   = 2'b01,
      ST_DRAIN = 2'b10
   } state_type;

   state_type              state_ff, state_in;
   logic [STAMP_W-1:0]     own_stamp_ff, own_stamp_in;
   logic                   requesting_ff, requesting_in;
   logic                   in_section_ff, in_section_in;
   logic [MAX_NODES-1:0]   granted_ff, granted_in;
   logic [PEER_N-1:0]      deferred_ff, deferred_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_event_ff, rsp_event_in;
   logic [PEER_W-1:0]      rsp_dest_ff, rsp_dest_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   load;
   logic                   can_emit;
   logic [CNT_W-1:0]       n_eff;
   logic [MAX_NODES-1:0]   need;
   logic [MAX_NODES-1:0]   granted_nx;
   logic                   prio;
   logic [PEER_W-1:0]      low_idx;
   logic [PEER_N-1:0]      low_bit;

   assign n_eff    = eff_nodes(cfg.node_count, MAX_N);
   assign can_emit = !rsp_valid_ff || rsp.ready;

   always_comb begin
      for (int i = 0; i < MAX_NODES; i++) begin
         need[i] = (CNT_W'(i) < n_eff) && (CNT_W'(i) != CNT_W'(cfg.own_id));
      end
   end

   assign granted_nx = granted_ff | (MAX_NODES'(1) << q_cmd.peer);

   always_comb begin
      if (in_section_ff) begin
         prio = 1'b0;
      end else if (requesting_ff) begin
         prio = (q_cmd.stamp < own_stamp_ff) ||
                ((q_cmd.stamp == own_stamp_ff) && (q_cmd.peer < cfg.own_id));
      end else begin
         prio = 1'b1;
      end
   end

   // lowest deferred peer
   always_comb begin
      low_idx = '0;
      for (int i = PEER_N - 1; i >= 0; i--) begin
         if (deferred_ff[i]) begin
            low_idx = PEER_W'(i);
         end
      end
   end

   assign low_bit = PEER_N'(1) << low_idx;

   always_comb begin
      state_in      = state_ff;
      own_stamp_in  = own_stamp_ff;
      requesting_in = requesting_ff;
      in_section_in = in_section_ff;
      granted_in    = granted_ff;
      deferred_in   = deferred_ff;
      pop           = 1'b0;
      load          = 1'b0;
      rsp_event_in  = EV_PERMIT;
      rsp_dest_in   = '0;
      rsp_last_in   = 1'b1;
      unique case (state_ff)
         ST_RUN: begin
            if (q_valid && can_emit) begin
               pop = 1'b1;
               case (q_cmd.kind)
                  KIND_LOCAL_REQ: begin
                     if (!requesting_ff && !in_section_ff) begin
                        own_stamp_in  = q_cmd.stamp;
                        requesting_in = 1'b1;
                        granted_in    = '0;
                        if (need == '0) begin
                           requesting_in = 1'b0;
                           in_section_in = 1'b1;
                           load          = 1'b1;
                           rsp_event_in  = EV_GRANT;
                        end
                     end
                  end
                  KIND_PEER_REQ: begin
                     if (prio) begin
                        load        = 1'b1;
                        rsp_dest_in = q_cmd.peer;
                     end else begin
                        deferred_in = deferred_ff | (PEER_N'(1) << q_cmd.peer);
                     end
                  end
                  KIND_PERMIT: begin
                     if (requesting_ff) begin
                        granted_in = granted_nx;
                        if ((granted_nx & need) == need) begin
                           requesting_in = 1'b0;
                           in_section_in = 1'b1;
                           load          = 1'b1;
                           rsp_event_in  = EV_GRANT;
                        end
                     end
                  end
                  default: begin
                     if (in_section_ff) begin
                        in_section_in = 1'b0;
                        granted_in    = '0;
                        if (deferred_ff != '0) begin
                           state_in = ST_DRAIN;
                        end
                     end
                  end
               endcase
            end
         end
         ST_DRAIN: begin
            if (can_emit) begin
               load        = 1'b1;
               rsp_dest_in = low_idx;
               deferred_in = deferred_ff & ~low_bit;
               rsp_last_in = ((deferred_ff & ~low_bit) == '0);
               if (rsp_last_in) begin
                  state_in = ST_RUN;
               end
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   assign rsp_valid_in = load || (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_RUN;
         own_stamp_ff  <= '0;
         requesting_ff <= 1'b0;
         in_section_ff <= 1'b0;
         granted_ff    <= '0;
         deferred_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         own_stamp_ff  <= own_stamp_in;
         requesting_ff <= requesting_in;
         in_section_ff <= in_section_in;
         granted_ff    <= granted_in;
         deferred_ff   <= deferred_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_event_ff <= rsp_event_in;
         rsp_dest_ff  <= rsp_dest_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.event_res = rsp_event_ff;
   assign rsp.dest      = rsp_dest_ff;
   assign rsp.last      = rsp_last_ff;

`ifndef SYNTHESIS
   a_drain_has_work: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DRAIN |-> deferred_ff != '0)
      else $error("drain with nothing deferred");

   a_exclusive_flags: assert property (@(posedge clock) disable iff (reset)
      !(requesting_ff && in_section_ff))
      else $error("requesting and in section at once");

   a_drain_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DRAIN |-> !requesting_ff && !in_section_ff && !pop)
      else $error("drain overlaps protocol activity");

   a_grant_enters: assert property (@(posedge clock) disable iff (reset)
      load && rsp_event_in == EV_GRANT |=> in_section_ff && !requesting_ff)
      else $error("grant without section entry");
`endif

endmodule

// ===== rtl/core/mutual_exclusion_node_core.sv =====
// ----------------------------------------------------------------------------
// mutual_exclusion_node_core
// One node of Ricart-Agrawala mutual exclusion.
// ----------------------------------------------------------------------------
// req carries events (local request, peer request, peer permission, local
// release); rsp carries permissions to send and the critical section grant,
// with last set on the final result of an event; csr writes own_id (0) and
// node_count (1), and is always ready.
// The front takes one event per cycle, while the queue is not full, into a
// two-entry queue; the back handles one queued event per cycle while the
// result register is free and no release drains. An event passes the queue
// and the result register before its result shows on rsp. A release sends
// one permission per cycle, unless rsp stalls, to each deferred peer in
// ascending id order, occupying the back until the last one is sent.
// The back takes the next event only when the result register is empty or
// being read; when rsp stalls the back holds, the queue fills and req.ready
// drops.
// Reset clears all protocol state and sets own_id to 0 and node_count to 2;
// no clearing pass is needed.
// ----------------------------------------------------------------------------
module mutual_exclusion_node_core
   import mexn_pkg::*;
#(
   parameter int unsigned MAX_NODES   = MAX_NODES_DEF,
   parameter int unsigned STAMP_LIMIT = STAMP_LIMIT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   mexn_req_if.sink    req,
   mexn_rsp_if.source  rsp,
   mexn_csr_if.sink    csr
);

   logic [PEER_W-1:0] own_id_ff;
   logic [NODE_W-1:0] node_count_ff;
   cfg_type           cfg;
   logic              q_full;
   logic              push;
   cmd_type           push_cmd;
   logic              pop;
   logic              pop_valid;
   cmd_type           pop_cmd;
   csr_index_type     csr_idx;

   assign csr.ready = 1'b1;
   assign csr_idx   = csr_index_type'(csr.index);

   always_ff @(posedge clock) begin
      if (reset) begin
         own_id_ff     <= '0;
         node_count_ff <= NODE_W'(2);
      end else if (csr.valid) begin
         unique case (csr_idx)
            CSR_OWN_ID:     own_id_ff     <= csr.data[PEER_W-1:0];
            CSR_NODE_COUNT: node_count_ff <= csr.data[NODE_W-1:0];
            default: ;
         endcase
      end
   end

   assign cfg.own_id     = own_id_ff;
   assign cfg.node_count = node_count_ff;

   mexn_front #(
      .MAX_NODES   (MAX_NODES),
      .STAMP_LIMIT (STAMP_LIMIT)
   ) u_front (
      .req      (req),
      .cfg      (cfg),
      .q_full   (q_full),
      .push     (push),
      .push_cmd (push_cmd)
   );

   mexn_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (q_full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_cmd   (pop_cmd)
   );

   mexn_back #(
      .MAX_NODES (MAX_NODES)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .q_valid (pop_valid),
      .q_cmd   (pop_cmd),
      .pop     (pop),
      .rsp     (rsp)
   );

endmodule
